// ===== hw/rtl/fwvp_pkg.sv =====
// ============================================================================
// fwvp_pkg
// Shared widths, codes, beat types and controller/datapath links for the
// four-wheel velocity PID block.
// ============================================================================
package fwvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEL_W     = 32;
    localparam int TIME_W    = 20;
    localparam int LIM_W     = 31;
    localparam int GAIN_W    = 32;
    localparam int ERR_W     = 33;
    localparam int WHEEL_W   = 2;
    localparam int WHEELS    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int STAT_W    = 2;

    // iterative arithmetic unit
    localparam int MAG_W   = 34;               // operand magnitude
    localparam int MULA_W  = 54;               // multiplicand
    localparam int MULB_W  = 56;               // multiplier, one byte per cycle
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int DVD_W   = 54;               // dividend, one bit per cycle
    localparam int DVS_W   = TIME_W;
    localparam int CNT_W   = 6;
    localparam int SUM_W   = 54;
    localparam int TERM_W  = MAG_W + GAIN_W - FRAC_BITS;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MULB_W / 8 - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    localparam logic [TIME_W-1:0] US_PER_S = 20'd1000000;

    // ceil(2^73 / 1000000): exact floor quotient for dividends below 2^53
    localparam int                RCP_SHIFT = 73;
    localparam logic [MULB_W-1:0] RECIP_US  = 56'd9444732965739291;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TLIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VLIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd6;

    localparam logic [STAT_W-1:0] STAT_COMPUTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DISABLED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd2;

    typedef struct packed {
        logic signed [VEL_W-1:0] req_front_left;
        logic signed [VEL_W-1:0] req_back_left;
        logic signed [VEL_W-1:0] req_back_right;
        logic signed [VEL_W-1:0] req_front_right;
        logic signed [VEL_W-1:0] meas_front_left;
        logic signed [VEL_W-1:0] meas_back_left;
        logic signed [VEL_W-1:0] meas_back_right;
        logic signed [VEL_W-1:0] meas_front_right;
        logic [TIME_W-1:0]       elapsed_us;
        logic                    enable;
    } in_beat_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] effort_front_left;
        logic signed [VEL_W-1:0] effort_back_left;
        logic signed [VEL_W-1:0] effort_back_right;
        logic signed [VEL_W-1:0] effort_front_right;
        logic [STAT_W-1:0]       step_status;
    } out_beat_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC_MUL,
        OP_ACC_RCP,
        OP_DELTA,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_I_MUL,
        OP_I_RCP,
        OP_I_ACC,
        OP_D_SUB,
        OP_D_MUL,
        OP_D_DIV,
        OP_D_SAT,
        OP_D_ZERO,
        OP_G0,
        OP_G1,
        OP_G2,
        OP_G_ADD,
        OP_CLAMP,
        OP_OUT_COMP,
        OP_OUT_DIS,
        OP_OUT_REJ
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [WHEEL_W-1:0] wheel;
    } dp_cmd_t;

    typedef struct packed {
        logic enable;
        logic dt_zero;
        logic hist_valid;
        logic arith_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/four_wheel_velocity_pid.sv =====
// ============================================================================
// four_wheel_velocity_pid
// Four-wheel PID velocity loop with request clamp, target slew, integral clamp
// and torque clamp, built as a sequencer over one shared arithmetic unit.
// ============================================================================
// Operation: an enabled step runs each multiply as a 7-byte byte-serial pass,
//   divides by a million as a reciprocal multiply, and per wheel adds a
//   bit-serial divide by elapsed time for the derivative; the first step after
//   reset or disable skips the derivative multiply and divide. Disabled or
//   zero-time beats go straight from the decision to the output register.
// Throughput: one beat in flight; the next beat is taken as soon as the result
//   sits in the output register, even while it waits for out_ready.
// Reset: rst_n clears wheel state, history, the sequencer and loads the
//   register defaults; no clearing pass is needed.
module four_wheel_velocity_pid
    import fwvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // sequencer: decides each micro-step and owns the output valid
    fwvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: registers, wheel state, shared multiply/divide, output beat
    fwvp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

    // hold off a second beat until the first has been worked
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a beat is in progress");

    // disabled and rejected beats carry zero efforts
    a_zero_effort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.step_status != STAT_COMPUTED |->
            out_data.effort_front_left == '0 && out_data.effort_back_left == '0 &&
            out_data.effort_back_right == '0 && out_data.effort_front_right == '0)
        else $error("nonzero effort on a non-computed beat");

    // a new result only comes out of a working sequencer
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared from idle");

endmodule

// ===== hw/rtl/fwvp_ctrl.sv =====
// ============================================================================
// fwvp_ctrl
// Sequencer: walks the datapath through one step, wheel by wheel.
// ============================================================================
module fwvp_ctrl
    import fwvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_ACC_RCP, S_DELTA, S_T1, S_T2, S_T3, S_I_MUL,
        S_I_RCP, S_I_ACC, S_D_SUB, S_D_MUL, S_D_DIV, S_D_SAT, S_D_ZERO,
        S_G0, S_G0_ADD, S_G1, S_G1_ADD, S_G2, S_G2_ADD, S_CLAMP,
        S_OUT_COMP, S_OUT_DIS, S_OUT_REJ, S_WAIT
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        wheel_next     = wheel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.wheel      = wheel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!st.enable)
                begin
                    state_next = S_OUT_DIS;
                end
                else if (st.dt_zero)
                begin
                    state_next = S_OUT_REJ;
                end
                else
                begin
                    cmd.op     = OP_ACC_MUL;
                    ret_next   = S_ACC_RCP;
                    state_next = S_WAIT;
                end
            end
            S_ACC_RCP:
            begin
                cmd.op     = OP_ACC_RCP;
                ret_next   = S_DELTA;
                state_next = S_WAIT;
            end
            S_DELTA:
            begin
                cmd.op     = OP_DELTA;
                wheel_next = '0;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.op     = OP_T1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.op     = OP_T2;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.op     = OP_T3;
                state_next = S_I_MUL;
            end
            S_I_MUL:
            begin
                cmd.op     = OP_I_MUL;
                ret_next   = S_I_RCP;
                state_next = S_WAIT;
            end
            S_I_RCP:
            begin
                cmd.op     = OP_I_RCP;
                ret_next   = S_I_ACC;
                state_next = S_WAIT;
            end
            S_I_ACC:
            begin
                cmd.op     = OP_I_ACC;
                state_next = st.hist_valid ? S_D_SUB : S_D_ZERO;
            end
            S_D_SUB:
            begin
                cmd.op     = OP_D_SUB;
                state_next = S_D_MUL;
            end
            S_D_MUL:
            begin
                cmd.op     = OP_D_MUL;
                ret_next   = S_D_DIV;
                state_next = S_WAIT;
            end
            S_D_DIV:
            begin
                cmd.op     = OP_D_DIV;
                ret_next   = S_D_SAT;
                state_next = S_WAIT;
            end
            S_D_SAT:
            begin
                cmd.op     = OP_D_SAT;
                state_next = S_G0;
            end
            S_D_ZERO:
            begin
                cmd.op     = OP_D_ZERO;
                state_next = S_G0;
            end
            S_G0:
            begin
                cmd.op     = OP_G0;
                ret_next   = S_G0_ADD;
                state_next = S_WAIT;
            end
            S_G0_ADD:
            begin
                cmd.op     = OP_G_ADD;
                state_next = S_G1;
            end
            S_G1:
            begin
                cmd.op     = OP_G1;
                ret_next   = S_G1_ADD;
                state_next = S_WAIT;
            end
            S_G1_ADD:
            begin
                cmd.op     = OP_G_ADD;
                state_next = S_G2;
            end
            S_G2:
            begin
                cmd.op     = OP_G2;
                ret_next   = S_G2_ADD;
                state_next = S_WAIT;
            end
            S_G2_ADD:
            begin
                cmd.op     = OP_G_ADD;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.op = OP_CLAMP;
                if (wheel_reg == WHEEL_W'(WHEELS - 1))
                begin
                    state_next = S_OUT_COMP;
                end
                else
                begin
                    wheel_next = wheel_reg + 1'b1;
                    state_next = S_T1;
                end
            end
            S_OUT_COMP, S_OUT_DIS, S_OUT_REJ:
            begin
                if (out_free)
                begin
                    unique case (state_reg)
                        S_OUT_COMP: cmd.op = OP_OUT_COMP;
                        S_OUT_DIS:  cmd.op = OP_OUT_DIS;
                        default:    cmd.op = OP_OUT_REJ;
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (!st.arith_busy)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/fwvp_datapath.sv =====
// ============================================================================
// fwvp_datapath
// Registers, wheel state, shared byte-serial multiplier and bit-serial divider.
// ============================================================================
module fwvp_datapath
    import fwvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_beat_t             in_data,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata,
    input  dp_cmd_t              cmd,
    output dp_status_t           st
);

    // configuration
    logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [LIM_W-1:0]  ilim_reg, tlim_reg, vlim_reg, accel_reg;

    // step operands and wheel state
    in_beat_t                in_reg, in_next;
    logic signed [VEL_W-1:0] target_reg [WHEELS];
    logic signed [VEL_W-1:0] integ_reg  [WHEELS];
    logic signed [ERR_W-1:0] last_reg   [WHEELS];
    logic signed [VEL_W-1:0] effort_reg [WHEELS];
    logic                    hist_reg, hist_next;
    logic signed [VEL_W-1:0] target_next [WHEELS];
    logic signed [VEL_W-1:0] integ_next  [WHEELS];
    logic signed [ERR_W-1:0] last_next   [WHEELS];
    logic signed [VEL_W-1:0] effort_next [WHEELS];

    logic [LIM_W-1:0]        delta_reg, delta_next;
    logic signed [MAG_W-1:0] diff_reg, diff_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [MAG_W-1:0] dd_reg, dd_next;
    logic signed [ERR_W-1:0] deriv_reg, deriv_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    out_beat_t               out_reg, out_next;

    // arithmetic unit
    logic              busy_reg, busy_next;
    logic              div_mode_reg, div_mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MULA_W-1:0] a_reg, a_next;
    logic [MULB_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic              sign_reg, sign_next;

    // combinational helpers
    logic signed [VEL_W-1:0] req_w, meas_w, tgt_w, integ_w;
    logic signed [ERR_W-1:0] vlim_s, req_s, reqc;
    logic signed [MAG_W-1:0] delta_s, step_s, tnew;
    logic signed [MAG_W-1:0] errx, integx, derivx;
    logic [MAG_W-1:0]        err_mag, integ_mag, deriv_mag, dd_mag;
    logic signed [MAG_W:0]   ddx;
    logic [MAG_W-1:0]        q34;
    logic signed [MAG_W:0]   inc_s, isum, ilim_s;
    logic [TERM_W-1:0]       term;
    logic signed [SUM_W-1:0] termx, tlim_s;
    logic [8+MULA_W-1:0]     pp;
    logic [DVS_W:0]          rem2;

    assign st.enable     = in_reg.enable;
    assign st.dt_zero    = (in_reg.elapsed_us == '0);
    assign st.hist_valid = hist_reg;
    assign st.arith_busy = busy_reg;
    assign out_data      = out_reg;

    always_comb
    begin
        unique case (cmd.wheel)
            2'd0:
            begin
                req_w  = in_reg.req_front_left;
                meas_w = in_reg.meas_front_left;
            end
            2'd1:
            begin
                req_w  = in_reg.req_back_left;
                meas_w = in_reg.meas_back_left;
            end
            2'd2:
            begin
                req_w  = in_reg.req_back_right;
                meas_w = in_reg.meas_back_right;
            end
            default:
            begin
                req_w  = in_reg.req_front_right;
                meas_w = in_reg.meas_front_right;
            end
        endcase
    end

    always_comb
    begin
        tgt_w   = target_reg[cmd.wheel];
        integ_w = integ_reg[cmd.wheel];

        vlim_s = signed'({2'b00, vlim_reg});
        req_s  = {req_w[VEL_W-1], req_w};
        if (req_s > vlim_s)
            reqc = vlim_s;
        else if (req_s < -vlim_s)
            reqc = -vlim_s;
        else
            reqc = req_s;

        delta_s = signed'({3'b000, delta_reg});
        if (diff_reg > delta_s)
            step_s = delta_s;
        else if (diff_reg < -delta_s)
            step_s = -delta_s;
        else
            step_s = diff_reg;
        tnew = {{2{tgt_w[VEL_W-1]}}, tgt_w} + step_s;

        errx      = {err_reg[ERR_W-1], err_reg};
        err_mag   = err_reg[ERR_W-1] ? MAG_W'(-errx) : MAG_W'(errx);
        integx    = {{2{integ_w[VEL_W-1]}}, integ_w};
        integ_mag = integ_w[VEL_W-1] ? MAG_W'(-integx) : MAG_W'(integx);
        derivx    = {deriv_reg[ERR_W-1], deriv_reg};
        deriv_mag = deriv_reg[ERR_W-1] ? MAG_W'(-derivx) : MAG_W'(derivx);
        ddx       = {dd_reg[MAG_W-1], dd_reg};
        dd_mag    = dd_reg[MAG_W-1] ? MAG_W'(-ddx) : MAG_W'(ddx);

        q34    = acc_reg[RCP_SHIFT +: MAG_W];
        inc_s  = sign_reg ? -signed'({1'b0, q34}) : signed'({1'b0, q34});
        isum   = {{3{integ_w[VEL_W-1]}}, integ_w} + inc_s;
        ilim_s = signed'({4'b0000, ilim_reg});

        term   = acc_reg[FRAC_BITS +: TERM_W];
        termx  = signed'({{(SUM_W-TERM_W){1'b0}}, term});
        tlim_s = signed'({{(SUM_W-LIM_W){1'b0}}, tlim_reg});

        pp   = a_reg * b_reg[7:0];
        rem2 = {rem_reg, dvd_reg[DVD_W-1]};
    end

    always_comb
    begin
        in_next       = in_reg;
        hist_next     = hist_reg;
        target_next   = target_reg;
        integ_next    = integ_reg;
        last_next     = last_reg;
        effort_next   = effort_reg;
        delta_next    = delta_reg;
        diff_next     = diff_reg;
        err_next      = err_reg;
        dd_next       = dd_reg;
        deriv_next    = deriv_reg;
        sum_next      = sum_reg;
        out_next      = out_reg;
        busy_next     = busy_reg;
        div_mode_next = div_mode_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        sign_next     = sign_reg;

        // advance the shared unit one byte or one quotient bit
        if (busy_reg)
        begin
            if (div_mode_reg)
            begin
                if (rem2 >= {1'b0, dvs_reg})
                begin
                    rem_next = DVS_W'(rem2 - {1'b0, dvs_reg});
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[DVS_W-1:0];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                busy_next = (cnt_reg != DIV_LAST);
            end
            else
            begin
                acc_next  = acc_reg + (PROD_W'(pp) << {cnt_reg[2:0], 3'b000});
                b_next    = b_reg >> 8;
                busy_next = (cnt_reg != MUL_LAST);
            end
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                in_next = in_data;
            end
            OP_ACC_MUL, OP_ACC_RCP, OP_I_MUL, OP_I_RCP, OP_D_MUL, OP_G0, OP_G1, OP_G2:
            begin
                busy_next     = 1'b1;
                div_mode_next = 1'b0;
                cnt_next      = '0;
                acc_next      = '0;
                unique case (cmd.op)
                    OP_ACC_MUL:
                    begin
                        a_next    = MULA_W'(accel_reg);
                        b_next    = MULB_W'(in_reg.elapsed_us);
                        sign_next = 1'b0;
                    end
                    OP_ACC_RCP, OP_I_RCP:
                    begin
                        // divide the last product by a million; hold the sign
                        a_next = acc_reg[MULA_W-1:0];
                        b_next = RECIP_US;
                    end
                    OP_I_MUL:
                    begin
                        a_next    = MULA_W'(err_mag);
                        b_next    = MULB_W'(in_reg.elapsed_us);
                        sign_next = err_reg[ERR_W-1];
                    end
                    OP_D_MUL:
                    begin
                        a_next    = MULA_W'(dd_mag);
                        b_next    = MULB_W'(US_PER_S);
                        sign_next = dd_reg[MAG_W-1];
                    end
                    OP_G0:
                    begin
                        a_next    = MULA_W'(err_mag);
                        b_next    = MULB_W'(kp_reg);
                        sign_next = err_reg[ERR_W-1];
                    end
                    OP_G1:
                    begin
                        a_next    = MULA_W'(integ_mag);
                        b_next    = MULB_W'(ki_reg);
                        sign_next = integ_w[VEL_W-1];
                    end
                    default:
                    begin
                        a_next    = MULA_W'(deriv_mag);
                        b_next    = MULB_W'(kd_reg);
                        sign_next = deriv_reg[ERR_W-1];
                    end
                endcase
            end
            OP_D_DIV:
            begin
                busy_next     = 1'b1;
                div_mode_next = 1'b1;
                cnt_next      = '0;
                rem_next      = '0;
                dvd_next      = acc_reg[DVD_W-1:0];
                dvs_next      = in_reg.elapsed_us;
            end
            OP_DELTA:
            begin
                delta_next = acc_reg[RCP_SHIFT +: LIM_W];
            end
            OP_T1:
            begin
                sum_next  = '0;
                diff_next = {reqc[ERR_W-1], reqc} - {{2{tgt_w[VEL_W-1]}}, tgt_w};
            end
            OP_T2:
            begin
                target_next[cmd.wheel] = tnew[VEL_W-1:0];
            end
            OP_T3:
            begin
                err_next = {tgt_w[VEL_W-1], tgt_w} - {meas_w[VEL_W-1], meas_w};
            end
            OP_I_ACC:
            begin
                if (isum > ilim_s)
                    integ_next[cmd.wheel] = VEL_W'(ilim_s);
                else if (isum < -ilim_s)
                    integ_next[cmd.wheel] = VEL_W'(-ilim_s);
                else
                    integ_next[cmd.wheel] = isum[VEL_W-1:0];
            end
            OP_D_SUB:
            begin
                dd_next = {err_reg[ERR_W-1], err_reg}
                        - {last_reg[cmd.wheel][ERR_W-1], last_reg[cmd.wheel]};
            end
            OP_D_SAT:
            begin
                if (sign_reg)
                begin
                    if (dvd_reg > DVD_W'(64'h1_0000_0000))
                        deriv_next = {1'b1, {(ERR_W-1){1'b0}}};
                    else
                        deriv_next = -signed'(dvd_reg[ERR_W-1:0]);
                end
                else
                begin
                    if (dvd_reg > DVD_W'(64'h0_FFFF_FFFF))
                        deriv_next = {1'b0, {(ERR_W-1){1'b1}}};
                    else
                        deriv_next = signed'(dvd_reg[ERR_W-1:0]);
                end
                last_next[cmd.wheel] = err_reg;
            end
            OP_D_ZERO:
            begin
                deriv_next           = '0;
                last_next[cmd.wheel] = err_reg;
            end
            OP_G_ADD:
            begin
                sum_next = sign_reg ? sum_reg - termx : sum_reg + termx;
            end
            OP_CLAMP:
            begin
                if (sum_reg > tlim_s)
                    effort_next[cmd.wheel] = VEL_W'(tlim_s);
                else if (sum_reg < -tlim_s)
                    effort_next[cmd.wheel] = VEL_W'(-tlim_s);
                else
                    effort_next[cmd.wheel] = sum_reg[VEL_W-1:0];
            end
            OP_OUT_COMP:
            begin
                out_next.effort_front_left  = effort_reg[0];
                out_next.effort_back_left   = effort_reg[1];
                out_next.effort_back_right  = effort_reg[2];
                out_next.effort_front_right = effort_reg[3];
                out_next.step_status        = STAT_COMPUTED;
                hist_next                   = 1'b1;
            end
            OP_OUT_DIS:
            begin
                out_next             = '0;
                out_next.step_status = STAT_DISABLED;
                hist_next            = 1'b0;
                for (int i = 0; i < WHEELS; i++)
                begin
                    target_next[i] = '0;
                    integ_next[i]  = '0;
                    last_next[i]   = '0;
                end
            end
            OP_OUT_REJ:
            begin
                out_next             = '0;
                out_next.step_status = STAT_REJECTED;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= GAIN_W'(65536);
            ki_reg    <= '0;
            kd_reg    <= '0;
            ilim_reg  <= LIM_W'(65536);
            tlim_reg  <= LIM_W'(65536);
            vlim_reg  <= LIM_W'(655360);
            accel_reg <= LIM_W'(655360);
            hist_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            for (int i = 0; i < WHEELS; i++)
            begin
                target_reg[i] <= '0;
                integ_reg[i]  <= '0;
                last_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KP:    kp_reg    <= cfg_wdata;
                    CFG_KI:    ki_reg    <= cfg_wdata;
                    CFG_KD:    kd_reg    <= cfg_wdata;
                    CFG_ILIM:  ilim_reg  <= cfg_wdata[LIM_W-1:0];
                    CFG_TLIM:  tlim_reg  <= cfg_wdata[LIM_W-1:0];
                    CFG_VLIM:  vlim_reg  <= cfg_wdata[LIM_W-1:0];
                    CFG_ACCEL: accel_reg <= cfg_wdata[LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            hist_reg   <= hist_next;
            busy_reg   <= busy_next;
            target_reg <= target_next;
            integ_reg  <= integ_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        effort_reg   <= effort_next;
        delta_reg    <= delta_next;
        diff_reg     <= diff_next;
        err_reg      <= err_next;
        dd_reg       <= dd_next;
        deriv_reg    <= deriv_next;
        sum_reg      <= sum_next;
        out_reg      <= out_next;
        div_mode_reg <= div_mode_next;
        cnt_reg      <= cnt_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        sign_reg     <= sign_next;
    end

endmodule
